### rtl/core/asww_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asww_pkg
// Shared constants, result codes and the queued command type of the
// aggregation slot window worker.
// ----------------------------------------------------------------------------
package asww_pkg;

  localparam int ElemsPerPkt = 64;
  localparam int Slots       = 16;
  localparam int MaxPkts     = 256;
  localparam int Contexts    = 4;
  localparam int MaxResults  = 16;

  // field widths
  localparam int CtxW   = 2;
  localparam int SizeW  = 15;
  localparam int OffW   = 14;
  localparam int SlotW  = 4;
  localparam int KindW  = 2;

  localparam int ElemShift   = $clog2(ElemsPerPkt);
  localparam int IdxW        = $clog2(MaxPkts);
  localparam int CntW        = $clog2(MaxPkts + 1);
  localparam int ExpRawW     = SizeW - ElemShift + 1;
  localparam int SendCap     = (Slots < MaxResults) ? Slots : MaxResults;
  localparam int NSendW      = $clog2(SendCap + 1);
  localparam int WindowElems = ElemsPerPkt * Slots;

  // received map is held as rows of RowBits bits
  localparam int RowBits  = 16;
  localparam int RowSelW  = $clog2(RowBits);
  localparam int RowIdxW  = IdxW - RowSelW;
  localparam int RowAddrW = CtxW + RowIdxW;
  localparam int Rows     = Contexts * MaxPkts / RowBits;

  typedef logic [KindW-1:0] kind_t;
  localparam kind_t KindSend = 2'd0;
  localparam kind_t KindDup  = 2'd1;
  localparam kind_t KindDone = 2'd2;
  localparam kind_t KindNone = 2'd3;

  localparam logic FuncStart  = 1'b0;
  localparam logic FuncArrive = 1'b1;

  typedef struct packed {
    logic              func;
    logic [CtxW-1:0]   ctx;
    logic [SizeW-1:0]  size;
    logic [OffW-1:0]   offset;
    logic              version;
    logic [SlotW-1:0]  slot;
    logic [CntW-1:0]   exp;
    logic [NSendW-1:0] nsend;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/core/asww_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asww_front
// Accepts command beats, works out expected packet and send counts for
// starts, and buffers classified commands in a two-entry queue.
// ----------------------------------------------------------------------------
module asww_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          func_i,
  input  wire logic [asww_pkg::CtxW-1:0]     context_req_i,
  input  wire logic [asww_pkg::SizeW-1:0]    grad_size_i,
  input  wire logic [asww_pkg::OffW-1:0]     in_offset_i,
  input  wire logic                          in_version_i,
  input  wire logic [asww_pkg::SlotW-1:0]    in_slot_i,
  input  wire logic                          pop_i,
  output logic                               q_valid_o,
  output asww_pkg::cmd_t                     q_cmd_o
);

  localparam int QDepth = 2;
  localparam int PtrW   = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  asww_pkg::cmd_t                    fifo_q [QDepth];
  logic [PtrW-1:0]                   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]                   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]                  cnt_q, cnt_d;
  logic                              push;
  logic                              pop;
  logic [asww_pkg::SizeW:0]          size_rnd;
  logic [asww_pkg::ExpRawW-1:0]      exp_raw;
  asww_pkg::cmd_t                    cmd_new;

  assign busy      = (cnt_q == QCntW'(QDepth));
  assign q_valid_o = (cnt_q != '0);
  assign q_cmd_o   = fifo_q[rd_ptr_q];
  assign push      = start && !busy;
  assign pop       = pop_i && q_valid_o;

  // ceil(size / elems per packet)
  always_comb begin
    size_rnd = {1'b0, grad_size_i} + (asww_pkg::SizeW + 1)'(asww_pkg::ElemsPerPkt - 1);
    exp_raw  = size_rnd[asww_pkg::SizeW:asww_pkg::ElemShift];

    cmd_new.func    = func_i;
    cmd_new.ctx     = context_req_i;
    cmd_new.size    = grad_size_i;
    cmd_new.offset  = in_offset_i;
    cmd_new.version = in_version_i;
    cmd_new.slot    = in_slot_i;
    cmd_new.exp     = (exp_raw > asww_pkg::ExpRawW'(asww_pkg::MaxPkts))
                      ? asww_pkg::CntW'(asww_pkg::MaxPkts) : asww_pkg::CntW'(exp_raw);
    cmd_new.nsend   = (exp_raw > asww_pkg::ExpRawW'(asww_pkg::SendCap))
                      ? asww_pkg::NSendW'(asww_pkg::SendCap) : asww_pkg::NSendW'(exp_raw);
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule
`default_nettype wire

### rtl/core/asww_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asww_back
// Executes queued commands: bursts of slot sends for starts, and a
// read-modify-write of the received map and counters for arrivals.
// ----------------------------------------------------------------------------
module asww_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire asww_pkg::cmd_t                q_cmd_i,
  output logic                               pop_o,
  output logic                               res_valid_o,
  output logic [asww_pkg::KindW-1:0]         kind_o,
  output logic [asww_pkg::OffW-1:0]          out_offset_o,
  output logic                               out_version_o,
  output logic [asww_pkg::SlotW-1:0]         out_slot_o,
  output logic [asww_pkg::SizeW-1:0]         out_size_o,
  output logic                               last_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSend = 2'd1;
  localparam logic [1:0] StRmw  = 2'd2;

  localparam int CtxN = asww_pkg::Contexts;

  logic [1:0]                         state_q, state_d;
  asww_pkg::cmd_t                     cmd_q, cmd_d;
  logic [asww_pkg::SlotW-1:0]         scnt_q, scnt_d;
  logic [asww_pkg::CntW-1:0]          exp_q [CtxN];
  logic [asww_pkg::CntW-1:0]          exp_d [CtxN];
  logic [asww_pkg::CntW-1:0]          rcv_q [CtxN];
  logic [asww_pkg::CntW-1:0]          rcv_d [CtxN];
  logic [asww_pkg::Rows-1:0]          rvalid_q, rvalid_d;

  logic [asww_pkg::RowBits-1:0]       mem [asww_pkg::Rows];
  logic [asww_pkg::RowBits-1:0]       rdata_q;
  logic                               mem_re;
  logic                               mem_we;
  logic [asww_pkg::RowAddrW-1:0]      rd_addr;
  logic [asww_pkg::RowAddrW-1:0]      wr_addr;
  logic [asww_pkg::RowBits-1:0]       mem_wdata;

  logic                               rv_q, rv_d;
  asww_pkg::kind_t                    kind_q, kind_d;
  logic [asww_pkg::OffW-1:0]          off_q, off_d;
  logic                               ver_q, ver_d;
  logic [asww_pkg::SlotW-1:0]         slot_q, slot_d;
  logic [asww_pkg::SizeW-1:0]         size_q, size_d;
  logic                               last_q, last_d;

  logic [asww_pkg::RowBits-1:0]       row;
  logic [asww_pkg::RowSelW-1:0]       bsel;
  logic [asww_pkg::CntW-1:0]          rcv_inc;
  logic [asww_pkg::OffW:0]            next_off;
  logic                               send_last;

  assign res_valid_o   = rv_q;
  assign kind_o        = kind_q;
  assign out_offset_o  = off_q;
  assign out_version_o = ver_q;
  assign out_slot_o    = slot_q;
  assign out_size_o    = size_q;
  assign last_o        = last_q;

  assign rd_addr = {q_cmd_i.ctx,
                    q_cmd_i.offset[asww_pkg::ElemShift+asww_pkg::IdxW-1:
                                   asww_pkg::ElemShift+asww_pkg::RowSelW]};
  assign wr_addr = {cmd_q.ctx,
                    cmd_q.offset[asww_pkg::ElemShift+asww_pkg::IdxW-1:
                                 asww_pkg::ElemShift+asww_pkg::RowSelW]};
  assign bsel    = cmd_q.offset[asww_pkg::ElemShift+asww_pkg::RowSelW-1:asww_pkg::ElemShift];

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    scnt_d    = scnt_q;
    exp_d     = exp_q;
    rcv_d     = rcv_q;
    rvalid_d  = rvalid_q;
    pop_o     = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    rv_d      = 1'b0;
    kind_d    = asww_pkg::KindNone;
    off_d     = '0;
    ver_d     = 1'b0;
    slot_d    = '0;
    size_d    = '0;
    last_d    = 1'b0;

    // a row never written since reset or completion reads as zero
    row       = rvalid_q[wr_addr] ? rdata_q : '0;
    mem_wdata = row | (asww_pkg::RowBits'(1) << bsel);
    rcv_inc   = rcv_q[cmd_q.ctx] + asww_pkg::CntW'(1);
    next_off  = {1'b0, cmd_q.offset} + (asww_pkg::OffW + 1)'(asww_pkg::WindowElems);
    send_last = ({1'b0, scnt_q} == (cmd_q.nsend - asww_pkg::NSendW'(1)));

    case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          pop_o = 1'b1;
          cmd_d = q_cmd_i;
          if (q_cmd_i.func == asww_pkg::FuncStart) begin
            exp_d[q_cmd_i.ctx] = q_cmd_i.exp;
            scnt_d             = '0;
            if (q_cmd_i.nsend == '0) begin
              rv_d   = 1'b1;
              kind_d = asww_pkg::KindNone;
              last_d = 1'b1;
            end else begin
              state_d = StSend;
            end
          end else begin
            mem_re  = 1'b1;
            state_d = StRmw;
          end
        end
      end
      StSend: begin
        rv_d   = 1'b1;
        kind_d = asww_pkg::KindSend;
        off_d  = asww_pkg::OffW'(scnt_q) << asww_pkg::ElemShift;
        slot_d = scnt_q;
        size_d = cmd_q.size;
        last_d = send_last;
        scnt_d = scnt_q + asww_pkg::SlotW'(1);
        if (send_last) begin
          state_d = StIdle;
        end
      end
      StRmw: begin
        rv_d    = 1'b1;
        last_d  = 1'b1;
        state_d = StIdle;
        if (row[bsel]) begin
          kind_d = asww_pkg::KindDup;
        end else if (rcv_inc == exp_q[cmd_q.ctx]) begin
          kind_d            = asww_pkg::KindDone;
          rcv_d[cmd_q.ctx]  = '0;
          for (int r = 0; r < asww_pkg::Rows; r++) begin
            if (asww_pkg::CtxW'(r >> asww_pkg::RowIdxW) == cmd_q.ctx) begin
              rvalid_d[r] = 1'b0;
            end
          end
        end else begin
          mem_we            = 1'b1;
          rvalid_d[wr_addr] = 1'b1;
          rcv_d[cmd_q.ctx]  = rcv_inc;
          if (next_off[asww_pkg::OffW] ||
              (asww_pkg::SizeW'(next_off) >= cmd_q.size)) begin
            kind_d = asww_pkg::KindNone;
          end else begin
            kind_d = asww_pkg::KindSend;
            off_d  = next_off[asww_pkg::OffW-1:0];
            ver_d  = ~cmd_q.version;
            slot_d = cmd_q.slot;
            size_d = cmd_q.size;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      scnt_q   <= '0;
      rvalid_q <= '0;
      rv_q     <= 1'b0;
      for (int c = 0; c < CtxN; c++) begin
        exp_q[c] <= '0;
        rcv_q[c] <= '0;
      end
    end else begin
      state_q  <= state_d;
      scnt_q   <= scnt_d;
      rvalid_q <= rvalid_d;
      rv_q     <= rv_d;
      exp_q    <= exp_d;
      rcv_q    <= rcv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    kind_q <= kind_d;
    off_q  <= off_d;
    ver_q  <= ver_d;
    slot_q <= slot_d;
    size_q <= size_d;
    last_q <= last_d;
  end

  // received map rows
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/aggregation_slot_window_worker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aggregation_slot_window_worker
// Worker side of a slot and window protocol for in-network aggregation:
// a front queue of classified commands feeding a back end that issues sends.
// ----------------------------------------------------------------------------
// Path: with the back end idle, an empty start answers from the queue straight
// to the result register; sends and arrivals also pass the send state or map read.
// Pace: an arrival takes a map row read, then the write and result; a start
// issues its sends in turn; the back end sets the pace, the queue buffers beats.
// Reset: queue, counters and per-row valid flags of the received map clear at
// once; no clearing pass, the block takes a beat straight after reset.
module aggregation_slot_window_worker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          func_i,
  input  wire logic [asww_pkg::CtxW-1:0]     context_req_i,
  input  wire logic [asww_pkg::SizeW-1:0]    grad_size_i,
  input  wire logic [asww_pkg::OffW-1:0]     in_offset_i,
  input  wire logic                          in_version_i,
  input  wire logic [asww_pkg::SlotW-1:0]    in_slot_i,
  output logic                               res_valid_o,
  output logic [asww_pkg::KindW-1:0]         kind_o,
  output logic [asww_pkg::OffW-1:0]          out_offset_o,
  output logic                               out_version_o,
  output logic [asww_pkg::SlotW-1:0]         out_slot_o,
  output logic [asww_pkg::SizeW-1:0]         out_size_o,
  output logic                               last_o
);

  logic           q_valid;
  logic           q_pop;
  asww_pkg::cmd_t q_cmd;

  asww_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .context_req_i (context_req_i),
    .grad_size_i   (grad_size_i),
    .in_offset_i   (in_offset_i),
    .in_version_i  (in_version_i),
    .in_slot_i     (in_slot_i),
    .pop_i         (q_pop),
    .q_valid_o     (q_valid),
    .q_cmd_o       (q_cmd)
  );

  asww_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd),
    .pop_o         (q_pop),
    .res_valid_o   (res_valid_o),
    .kind_o        (kind_o),
    .out_offset_o  (out_offset_o),
    .out_version_o (out_version_o),
    .out_slot_o    (out_slot_o),
    .out_size_o    (out_size_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire
